/* rtl/pgf_pkg.sv */
// Shared constants for the pairwise gravity force pipeline.
// No dependencies; used by pgf_mul, pgf_div and pairwise_gravity_force.
package pgf_pkg;

	localparam int CHUNK_W    = 32;   // partial product operand width
	localparam int GRAV_W     = 32;   // grav_constant register width, Q8.24
	localparam int GRAV_FRAC  = 24;   // fraction bits of grav_constant
	localparam int FORCE_W    = 48;   // width of each force component
	localparam int OUT_W      = 3 * FORCE_W;
	localparam int FLAG_ZERO  = 0;    // tuser bit: coincident positions
	localparam int FLAG_SAT   = 1;    // tuser bit: a component was clipped
	localparam int FLAG_W     = 2;

	localparam logic [GRAV_W-1:0]  GRAV_RESET = GRAV_W'(1);
	localparam logic [FORCE_W-1:0] FORCE_MAX  = {1'b0, {(FORCE_W-1){1'b1}}};
	localparam logic [FORCE_W-1:0] FORCE_MIN  = {1'b1, {(FORCE_W-1){1'b0}}};

endpackage

/* rtl/pgf_mul.sv */
// Two-stage unsigned multiplier: 32x32 partial products, then their sum.
// Depends on pgf_pkg for the chunk width.
module pgf_mul #(
	parameter int WA = 32,
	parameter int WB = 32
) (
	input  logic             clk,
	input  logic             en,
	input  logic [WA-1:0]    a,
	input  logic [WB-1:0]    b,
	output logic [WA+WB-1:0] p
);

	localparam int CW = pgf_pkg::CHUNK_W;
	localparam int NA = (WA + CW - 1) / CW;
	localparam int NB = (WB + CW - 1) / CW;
	localparam int PA = NA * CW;
	localparam int PB = NB * CW;
	localparam int PW = PA + PB;

	logic [PA-1:0]     a_pad;
	logic [PB-1:0]     b_pad;
	logic [2*CW-1:0]   pp_s1 [NA*NB];
	logic [PW-1:0]     acc;
	logic [PW-1:0]     p_s2;

	assign a_pad = PA'(a);
	assign b_pad = PB'(b);

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < NA; i++) begin
				for (int j = 0; j < NB; j++) begin
					pp_s1[i*NB+j] <= (2*CW)'(a_pad[i*CW +: CW]) * (2*CW)'(b_pad[j*CW +: CW]);
				end
			end
		end
	end

	always_comb begin
		acc = '0;
		for (int i = 0; i < NA; i++) begin
			for (int j = 0; j < NB; j++) begin
				acc = acc + (PW'(pp_s1[i*NB+j]) << ((i + j) * CW));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s2 <= acc;
		end
	end

	assign p = p_s2[WA+WB-1:0];

endmodule

/* rtl/pgf_div.sv */
// Pipelined restoring divider: overflow check, then one quotient bit per stage.
// Gives a FORCE_W-bit quotient, valid while the flag is low, and a flag for quotients of 2^FORCE_W and up.
// Depends on pgf_pkg.
module pgf_div #(
	parameter int NW = 177,
	parameter int DW = 123
) (
	input  logic                        clk,
	input  logic                        en,
	input  logic [NW-1:0]               num,
	input  logic [DW-1:0]               den,
	output logic [pgf_pkg::FORCE_W-1:0] q,
	output logic                        big
);

	localparam int FW = pgf_pkg::FORCE_W;
	localparam int CW = ((NW > DW + FW) ? NW : DW + FW) + 1;

	logic [NW-1:0] rem_s [FW];
	logic [DW-1:0] den_s [FW];
	logic [FW-1:0] q_s   [FW+1];
	logic          big_s [FW+1];

	function automatic logic fits(logic [NW-1:0] r, logic [DW-1:0] d, int sh);
		return CW'(r) >= (CW'(d) << sh);
	endfunction

	function automatic logic [NW-1:0] reduce(logic [NW-1:0] r, logic [DW-1:0] d, int sh);
		return NW'(CW'(r) - (CW'(d) << sh));
	endfunction

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= num;
			den_s[0] <= den;
			q_s[0]   <= '0;
			big_s[0] <= fits(num, den, FW);
			for (int k = 0; k < FW; k++) begin
				big_s[k+1] <= big_s[k];
				q_s[k+1]   <= fits(rem_s[k], den_s[k], FW - 1 - k) ?
					(q_s[k] | (FW'(1) << (FW - 1 - k))) : q_s[k];
			end
			for (int k = 0; k < FW - 1; k++) begin
				den_s[k+1] <= den_s[k];
				rem_s[k+1] <= fits(rem_s[k], den_s[k], FW - 1 - k) ?
					reduce(rem_s[k], den_s[k], FW - 1 - k) : rem_s[k];
			end
		end
	end

	assign q   = q_s[FW];
	assign big = big_s[FW];

endmodule

/* rtl/pairwise_gravity_force.sv */
// Pairwise Newtonian gravity force, fully pipelined.
// Throughput: one body pair per cycle; the whole pipe holds only when the output
// register is full and not taken. Stages: difference, squares, bit-serial square
// root (one stage per root bit), cube of distance, product chain, divide (an
// overflow check, then 48 quotient-bit stages), zero/sign/clip output register.
// Reset clears all valid bits and loads grav_constant with a raw value of 1 (2^-24 in Q8.24).
module pairwise_gravity_force #(
	parameter int COORD_BITS = 32,
	parameter int MASS_BITS  = 32
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_wr_en,
	input  logic [pgf_pkg::GRAV_W-1:0]         cfg_wr_data,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// self_x, self_y, self_z, other_x, other_y, other_z, self_mass, other_mass
	input  logic [((6*COORD_BITS+2*MASS_BITS+7)/8)*8-1:0] s_tdata,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// force_x, force_y, force_z
	output logic [pgf_pkg::OUT_W-1:0]          m_tdata,
	// zero_distance, saturated
	output logic [pgf_pkg::FLAG_W-1:0]         m_tuser
);

	localparam int CB     = COORD_BITS;
	localparam int MB     = MASS_BITS;
	localparam int GW     = pgf_pkg::GRAV_W;
	localparam int FW     = pgf_pkg::FORCE_W;
	localparam int AW     = CB + 1;            // |difference|
	localparam int SW     = 2 * CB + 2;        // sum of squares
	localparam int RW     = CB + 1;            // root
	localparam int DENW   = 3 * RW + pgf_pkg::GRAV_FRAC;
	localparam int K1W    = GW + MB;
	localparam int KW     = GW + 2 * MB;
	localparam int NW     = KW + AW;
	localparam int T_SUM  = 4;
	localparam int T_ROOT = T_SUM + RW;
	localparam int T_DEN  = T_ROOT + 4;
	localparam int T_Q    = T_DEN + 1 + FW;
	localparam int LAT    = T_Q + 1;

	logic en;
	logic vld_q [LAT];
	logic [GW-1:0] grav_q;

	logic [2:0][CB-1:0] self_c, other_c;
	logic [2:0][AW-1:0] absd_c;
	logic [2:0]         neg_c;

	logic [2:0][AW-1:0] absd_dly [T_DEN-2];
	logic [2:0]         neg_dly  [T_Q];
	logic               zero_dly [T_Q-3];
	logic [GW-1:0]      grav_dly [T_DEN-6];
	logic [MB-1:0]      m1_dly   [T_DEN-6];
	logic [MB-1:0]      m2_dly   [T_DEN-4];
	logic [RW-1:0]      root_dly [2];

	logic [2*AW-1:0]    sqr [3];
	logic [SW-1:0]      sum_c;
	logic [SW-1:0]      sq_rem  [RW];
	logic [RW-1:0]      sq_root [RW+1];

	logic [2*RW-1:0]    r2;
	logic [3*RW-1:0]    r3;
	logic [DENW-1:0]    den;
	logic [K1W-1:0]     k1;
	logic [KW-1:0]      k;
	logic [NW-1:0]      num [3];
	logic [FW-1:0]      quo [3];
	logic               big [3];

	logic [2:0][FW-1:0] force_c;
	logic [2:0]         sat_c;
	logic [2:0][FW-1:0] force_s;
	logic               zero_s, sat_s;

	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grav_q <= pgf_pkg::GRAV_RESET;
		end else if (cfg_wr_en) begin
			grav_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LAT; i++) vld_q[i] <= 1'b0;
		end else if (en) begin
			vld_q[0] <= s_tvalid;
			for (int i = 1; i < LAT; i++) vld_q[i] <= vld_q[i-1];
		end
	end

	// difference other - self, split into magnitude and sign
	always_comb begin
		for (int a = 0; a < 3; a++) begin
			logic [AW-1:0] d;
			self_c[a]  = s_tdata[a*CB +: CB];
			other_c[a] = s_tdata[(a+3)*CB +: CB];
			d = {other_c[a][CB-1], other_c[a]} - {self_c[a][CB-1], self_c[a]};
			neg_c[a]  = d[AW-1];
			absd_c[a] = d[AW-1] ? (~d + AW'(1)) : d;
		end
	end

	// delay lines; index 0 is stage 1 except where noted
	always_ff @(posedge clk) begin
		if (en) begin
			absd_dly[0] <= absd_c;
			neg_dly[0]  <= neg_c;
			grav_dly[0] <= grav_q;
			m1_dly[0]   <= s_tdata[6*CB +: MB];
			m2_dly[0]   <= s_tdata[6*CB+MB +: MB];
			for (int i = 1; i < T_DEN - 2; i++) absd_dly[i] <= absd_dly[i-1];
			for (int i = 1; i < T_Q; i++)       neg_dly[i]  <= neg_dly[i-1];
			for (int i = 1; i < T_DEN - 6; i++) grav_dly[i] <= grav_dly[i-1];
			for (int i = 1; i < T_DEN - 6; i++) m1_dly[i]   <= m1_dly[i-1];
			for (int i = 1; i < T_DEN - 4; i++) m2_dly[i]   <= m2_dly[i-1];
			// index 0 is stage T_SUM
			zero_dly[0] <= (sum_c == '0);
			for (int i = 1; i < T_Q - 3; i++)   zero_dly[i] <= zero_dly[i-1];
			// index 0 is stage T_ROOT + 1
			root_dly[0] <= sq_root[RW];
			root_dly[1] <= root_dly[0];
		end
	end

	for (genvar a = 0; a < 3; a++) begin : g_sq
		pgf_mul #(.WA(AW), .WB(AW)) u_sq (
			.clk(clk), .en(en), .a(absd_dly[0][a]), .b(absd_dly[0][a]), .p(sqr[a])
		);
	end

	assign sum_c = SW'(sqr[0]) + SW'(sqr[1]) + SW'(sqr[2]);

	// square root, one result bit per stage, highest bit first
	function automatic logic sq_fits(logic [SW-1:0] r, logic [RW-1:0] rt, int b);
		return (SW+1)'(r) >= (((SW+1)'(rt) << (b + 1)) | ((SW+1)'(1) << (2 * b)));
	endfunction

	function automatic logic [SW-1:0] sq_reduce(logic [SW-1:0] r, logic [RW-1:0] rt, int b);
		return SW'((SW+1)'(r) - (((SW+1)'(rt) << (b + 1)) | ((SW+1)'(1) << (2 * b))));
	endfunction

	always_ff @(posedge clk) begin
		if (en) begin
			sq_rem[0]  <= sum_c;
			sq_root[0] <= '0;
			for (int g = 0; g < RW; g++) begin
				sq_root[g+1] <= sq_fits(sq_rem[g], sq_root[g], CB - g) ?
					(sq_root[g] | (RW'(1) << (CB - g))) : sq_root[g];
			end
			for (int g = 0; g < RW - 1; g++) begin
				sq_rem[g+1] <= sq_fits(sq_rem[g], sq_root[g], CB - g) ?
					sq_reduce(sq_rem[g], sq_root[g], CB - g) : sq_rem[g];
			end
		end
	end

	pgf_mul #(.WA(RW), .WB(RW)) u_r2 (
		.clk(clk), .en(en), .a(sq_root[RW]), .b(sq_root[RW]), .p(r2)
	);

	pgf_mul #(.WA(2*RW), .WB(RW)) u_r3 (
		.clk(clk), .en(en), .a(r2), .b(root_dly[1]), .p(r3)
	);

	assign den = {r3, {pgf_pkg::GRAV_FRAC{1'b0}}};

	pgf_mul #(.WA(GW), .WB(MB)) u_k1 (
		.clk(clk), .en(en), .a(grav_dly[T_DEN-7]), .b(m1_dly[T_DEN-7]), .p(k1)
	);

	pgf_mul #(.WA(K1W), .WB(MB)) u_k (
		.clk(clk), .en(en), .a(k1), .b(m2_dly[T_DEN-5]), .p(k)
	);

	for (genvar a = 0; a < 3; a++) begin : g_axis
		pgf_mul #(.WA(KW), .WB(AW)) u_num (
			.clk(clk), .en(en), .a(k), .b(absd_dly[T_DEN-3][a]), .p(num[a])
		);

		pgf_div #(.NW(NW), .DW(DENW)) u_div (
			.clk(clk), .en(en), .num(num[a]), .den(den), .q(quo[a]), .big(big[a])
		);
	end

	// zero for coincident positions, else reapply sign and clip to the 48-bit range
	always_comb begin
		for (int a = 0; a < 3; a++) begin
			force_c[a] = '0;
			sat_c[a]   = 1'b0;
			if (zero_dly[T_Q-4]) begin
				force_c[a] = '0;
			end else if (neg_dly[T_Q-1][a]) begin
				if (big[a] || quo[a] > pgf_pkg::FORCE_MIN) begin
					force_c[a] = pgf_pkg::FORCE_MIN;
					sat_c[a]   = 1'b1;
				end else begin
					force_c[a] = ~quo[a] + FW'(1);
				end
			end else begin
				if (big[a] || quo[a] > pgf_pkg::FORCE_MAX) begin
					force_c[a] = pgf_pkg::FORCE_MAX;
					sat_c[a]   = 1'b1;
				end else begin
					force_c[a] = quo[a];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			force_s <= force_c;
			zero_s  <= zero_dly[T_Q-4];
			sat_s   <= |sat_c;
		end
	end

	assign m_tvalid = vld_q[LAT-1];
	assign m_tdata  = force_s;
	always_comb begin
		m_tuser = '0;
		m_tuser[pgf_pkg::FLAG_ZERO] = zero_s;
		m_tuser[pgf_pkg::FLAG_SAT]  = sat_s;
	end

endmodule
